FILE: hdl/ude_pkg.sv
// Shared types, calendar constants and helper functions for the UTC date to
// epoch seconds block. No dependencies.
package ude_pkg;

   // Years in one Gregorian cycle, and the days that such a cycle spans.
   localparam int unsigned YEARS_PER_CYCLE = 400;
   localparam logic signed [18:0] DAYS_PER_CYCLE = 19'sd146097;

   // x / 400 = (x >> 4) / 25; ceil(2^32 / 25) gives the exact quotient by 25
   // for any dividend below 2^30, taken from product bits 32 and up.
   localparam logic [27:0] RECIP_25 = 28'd171798692;

   // Folding window bounds in years since 1900.
   localparam logic signed [31:0] FOLD_HI = 32'sd100;
   localparam logic signed [31:0] FOLD_LO = -32'sd300;

   // Walk origin: 1970 and the year before it.
   localparam logic signed [9:0] EPOCH_YEAR = 10'sd70;
   localparam logic signed [9:0] PRE_EPOCH_YEAR = 10'sd69;

   localparam logic [8:0] YEAR_LEN_COMMON = 9'd365;
   localparam logic [8:0] YEAR_LEN_LEAP = 9'd366;

   // 86400 = 675 << 7
   localparam logic signed [10:0] SECS_DAY_ODD = 11'sd675;
   localparam int unsigned SECS_DAY_SHIFT = 7;

   localparam logic [3:0] LAST_MONTH = 4'd11;

   localparam logic [8:0] DAYS_BEFORE_COMMON [12] = '{
      9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
      9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
   };
   localparam logic [8:0] DAYS_BEFORE_LEAP [12] = '{
      9'd0, 9'd31, 9'd60, 9'd91, 9'd121, 9'd152,
      9'd182, 9'd213, 9'd244, 9'd274, 9'd305, 9'd335
   };

   typedef struct packed {
      logic load;
      logic div_step;
      logic fold;
      logic walk_step;
      logic month;
      logic mul;
      logic finish;
   } ude_cmd_type;

   typedef struct packed {
      logic walk_done;
   } ude_sts_type;

   // Leap test for a folded year (years since 1900, within -300..499).
   // The calendar year then lies in 1600..2399.
   function automatic logic is_leap(input logic signed [9:0] yr);
      logic signed [12:0] cal;
      logic [11:0] c;
      logic century;
      cal = 13'(yr) + 13'sd1900;
      c = cal[11:0];
      century = (c == 12'd1700) || (c == 12'd1800) || (c == 12'd1900) ||
                (c == 12'd2100) || (c == 12'd2200) || (c == 12'd2300) ||
                (c == 12'd1600) || (c == 12'd2400);
      // 1600, 2000 and 2400 are multiples of 400 and stay leap
      if ((c == 12'd1600) || (c == 12'd2000) || (c == 12'd2400)) begin
         century = 1'b0;
      end
      return (c[1:0] == 2'd0) && !century;
   endfunction

   function automatic logic [8:0] year_len(input logic signed [9:0] yr);
      return is_leap(yr) ? YEAR_LEN_LEAP : YEAR_LEN_COMMON;
   endfunction

   // Months past December read as December.
   function automatic logic [8:0] days_before(input logic leap, input logic [3:0] mon);
      logic [3:0] m;
      m = (mon > LAST_MONTH) ? LAST_MONTH : mon;
      return leap ? DAYS_BEFORE_LEAP[m] : DAYS_BEFORE_COMMON[m];
   endfunction

endpackage

FILE: hdl/utc_date_to_epoch_seconds.sv
// Top level of the UTC date to epoch seconds converter.
// Depends on ude_pkg, ude_ctrl and ude_datapath.
//
// Usage:
//  - Request channel (req_*): a broken-down UTC date, taken when req_valid is
//    high and req_stall is low. req_stall is high while a request is in work,
//    so one request is converted at a time.
//  - Response channel (rsp_*): one signed 64-bit seconds count per request,
//    held in an output register until rsp_valid meets a low rsp_stall.
//  - Steps from acceptance to rsp_valid: the divide by 400, the fold, the
//    year walk from 1970 to the folded year (0 to 429 years, one year a
//    cycle), the end-of-walk check, the month sum, the scaling and the
//    output write, which waits while the output register is still held.
//    The next request is taken after the result is written, so a request
//    is accepted only once the previous one is through.
//  - A stalled response does not block the next request: the block accepts
//    and converts it, and holds the new result until the old one is taken.
//  - Fields are summed linearly with no normalization; months past 11 count
//    as December.
//  - Reset (synchronous, active high) returns the sequencer to idle and
//    drops rsp_valid; any request in work is lost.
module utc_date_to_epoch_seconds (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [31:0] req_year_since_1900,
   input  logic [3:0]         req_month,
   input  logic [4:0]         req_day,
   input  logic [4:0]         req_hour,
   input  logic [5:0]         req_minute,
   input  logic [5:0]         req_second,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [63:0] rsp_epoch_seconds
);

   ude_pkg::ude_cmd_type cmd;
   ude_pkg::ude_sts_type sts;

   // sequencer: handshakes and step commands
   ude_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .sts       (sts)
   );

   // arithmetic: fold, walk, month sum, scaling, output register
   ude_datapath u_datapath (
      .clock               (clock),
      .cmd                 (cmd),
      .sts                 (sts),
      .req_year_since_1900 (req_year_since_1900),
      .req_month           (req_month),
      .req_day             (req_day),
      .req_hour            (req_hour),
      .req_minute          (req_minute),
      .req_second          (req_second),
      .rsp_epoch_seconds   (rsp_epoch_seconds)
   );

endmodule

FILE: hdl/ude_ctrl.sv
// Sequencer for the date conversion: handshakes and datapath commands.
// Depends on ude_pkg.
module ude_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output ude_pkg::ude_cmd_type cmd,
   input  ude_pkg::ude_sts_type sts
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_DIV,
      S_FOLD,
      S_WALK,
      S_MONTH,
      S_MUL,
      S_FINISH
   } state_type;

   localparam int unsigned DIV_STEPS = 1;

   state_type state_ff;
   logic [4:0] div_cnt_ff;
   logic       rsp_valid_ff;
   logic       out_free;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd = '0;
      case (state_ff)
         S_IDLE:   cmd.load = req_valid;
         S_DIV:    cmd.div_step = 1'b1;
         S_FOLD:   cmd.fold = 1'b1;
         S_WALK:   cmd.walk_step = !sts.walk_done;
         S_MONTH:  cmd.month = 1'b1;
         S_MUL:    cmd.mul = 1'b1;
         S_FINISH: cmd.finish = out_free;
         default:  cmd = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         div_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.finish) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               div_cnt_ff <= '0;
               if (req_valid) begin
                  state_ff <= S_DIV;
               end
            end
            S_DIV: begin
               div_cnt_ff <= div_cnt_ff + 5'd1;
               if (div_cnt_ff == 5'(DIV_STEPS - 1)) begin
                  state_ff <= S_FOLD;
               end
            end
            S_FOLD:  state_ff <= S_WALK;
            S_WALK: begin
               if (sts.walk_done) begin
                  state_ff <= S_MONTH;
               end
            end
            S_MONTH: state_ff <= S_MUL;
            S_MUL:   state_ff <= S_FINISH;
            S_FINISH: begin
               if (out_free) begin
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   a_finish_when_free: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> (!rsp_valid_ff || !rsp_stall))
      else $error("result written while output register still held");

   a_finish_shows: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |=> rsp_valid_ff)
      else $error("finished result not presented");

   a_div_full: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FOLD) |-> ($past(div_cnt_ff) == 5'(DIV_STEPS - 1)))
      else $error("fold entered before quotient ready");

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> (state_ff == S_DIV) && (div_cnt_ff == 5'd0))
      else $error("request not started cleanly");

endmodule

FILE: hdl/ude_datapath.sv
// Datapath for the date conversion: divider by 400, year walk, month and
// time-of-day sums, seconds scaling and output register. Depends on ude_pkg.
module ude_datapath (
   input  logic                 clock,
   input  ude_pkg::ude_cmd_type cmd,
   output ude_pkg::ude_sts_type sts,
   input  logic signed [31:0]   req_year_since_1900,
   input  logic [3:0]           req_month,
   input  logic [4:0]           req_day,
   input  logic [4:0]           req_hour,
   input  logic [5:0]           req_minute,
   input  logic [5:0]           req_second,
   output logic signed [63:0]   rsp_epoch_seconds
);

   logic signed [31:0] year_ff;
   logic [3:0]         month_ff;
   logic [4:0]         day_ff;
   logic [4:0]         hour_ff;
   logic [5:0]         minute_ff;
   logic [5:0]         second_ff;
   logic               neg_ff;
   logic               need_fold_ff;
   logic [31:0]        dvd_ff;
   logic [22:0]        quo_ff;
   logic signed [41:0] days_ff;
   logic signed [9:0]  k_ff;
   logic signed [9:0]  yf_ff;
   logic [16:0]        tod_ff;
   logic [30:0]        plo_ff;
   logic signed [30:0] phi_ff;
   logic signed [63:0] result_ff;

   // load
   logic signed [32:0] diff;
   logic signed [32:0] mag;
   logic               need_fold;

   assign diff      = {req_year_since_1900[31], req_year_since_1900} - 33'sd100;
   assign mag       = diff[32] ? -diff : diff;
   assign need_fold = (req_year_since_1900 > ude_pkg::FOLD_HI) ||
                      (req_year_since_1900 < ude_pkg::FOLD_LO);

   // divide by 400: drop four bits, then reciprocal multiply by 1/25
   logic [27:0] dvd_hi;
   logic [55:0] recip_prod;
   logic [8:0]  q400_lo;
   logic [8:0]  rem;

   assign dvd_hi     = dvd_ff[31:4];
   assign recip_prod = 56'(dvd_hi) * 56'(ude_pkg::RECIP_25);
   // remainder is below 400, so the low nine bits carry it exactly
   assign q400_lo    = quo_ff[8:0] * 9'(ude_pkg::YEARS_PER_CYCLE);
   assign rem        = dvd_ff[8:0] - q400_lo;

   // fold: quotient is below 2^23 for any 32-bit year
   logic signed [23:0] quo_s;
   logic signed [23:0] cyc;
   logic signed [9:0]  rem_s;
   logic signed [9:0]  yf_fold;
   logic signed [9:0]  yf_sel;
   logic signed [42:0] fold_prod;

   assign quo_s     = $signed({1'b0, quo_ff});
   assign cyc       = neg_ff ? -quo_s : quo_s;
   assign rem_s     = $signed({1'b0, rem});
   assign yf_fold   = 10'sd100 + (neg_ff ? -rem_s : rem_s);
   assign yf_sel    = need_fold_ff ? yf_fold : year_ff[9:0];
   assign fold_prod = cyc * ude_pkg::DAYS_PER_CYCLE;

   // year walk
   logic               walk_up;
   logic signed [41:0] len_s;

   assign walk_up       = yf_ff > ude_pkg::EPOCH_YEAR;
   assign sts.walk_done = walk_up ? (k_ff == yf_ff) : (k_ff < yf_ff);
   assign len_s         = $signed({33'd0, ude_pkg::year_len(k_ff)});

   // month, day and time of day
   logic signed [41:0] dbm_s;
   logic signed [41:0] day_s;
   logic [16:0]        tod_in;

   assign dbm_s  = $signed({33'd0, ude_pkg::days_before(ude_pkg::is_leap(yf_ff), month_ff)});
   assign day_s  = $signed({37'd0, day_ff});
   assign tod_in = 17'(hour_ff) * 17'd3600 + 17'(minute_ff) * 17'd60 + 17'(second_ff);

   // days * 675 as two partial products, then << 7
   logic signed [20:0] days_hi;
   logic [30:0]        plo_in;
   logic signed [30:0] phi_in;
   logic signed [63:0] phi_ext;
   logic signed [63:0] scaled;
   logic signed [63:0] secs;

   assign days_hi = days_ff[41:21];
   assign plo_in  = 31'(days_ff[20:0]) * 31'd675;
   assign phi_in  = days_hi * ude_pkg::SECS_DAY_ODD;
   assign phi_ext = {{33{phi_ff[30]}}, phi_ff};
   assign scaled  = (phi_ext <<< 21) + $signed({33'd0, plo_ff});
   assign secs    = (scaled <<< ude_pkg::SECS_DAY_SHIFT) + $signed({47'd0, tod_ff});

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         year_ff      <= req_year_since_1900;
         month_ff     <= req_month;
         day_ff       <= req_day;
         hour_ff      <= req_hour;
         minute_ff    <= req_minute;
         second_ff    <= req_second;
         neg_ff       <= diff[32];
         need_fold_ff <= need_fold;
         dvd_ff       <= mag[31:0];
         quo_ff       <= '0;
      end
      if (cmd.div_step) begin
         quo_ff <= recip_prod[54:32];
      end
      if (cmd.fold) begin
         days_ff <= need_fold_ff ? fold_prod[41:0] : '0;
         yf_ff   <= yf_sel;
         k_ff    <= (yf_sel > ude_pkg::EPOCH_YEAR) ? ude_pkg::EPOCH_YEAR
                                                   : ude_pkg::PRE_EPOCH_YEAR;
      end
      if (cmd.walk_step) begin
         days_ff <= walk_up ? days_ff + len_s : days_ff - len_s;
         k_ff    <= walk_up ? k_ff + 10'sd1 : k_ff - 10'sd1;
      end
      if (cmd.month) begin
         days_ff <= days_ff + dbm_s + day_s - 42'sd1;
         tod_ff  <= tod_in;
      end
      if (cmd.mul) begin
         plo_ff <= plo_in;
         phi_ff <= phi_in;
      end
      if (cmd.finish) begin
         result_ff <= secs;
      end
   end

   assign rsp_epoch_seconds = result_ff;

endmodule
